// ----- src/radar_trace_clutter_filter_defines.svh -----
// Assertion macros shared by the clutter filter modules.
`ifndef RADAR_TRACE_CLUTTER_FILTER_DEFINES_SVH
`define RADAR_TRACE_CLUTTER_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTCF_CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTCF_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rtcf_pkg.sv -----
// Shared constants, register codes and config bundle for the clutter filter.
`timescale 1ns / 1ps
package rtcf_pkg;
	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// Weights are in sixteenths.
	localparam int WT_FULL  = 16;
	localparam int WT_ROUND = 8;
	localparam int WT_SHIFT = 4;

	localparam int WT_W       = 5;
	localparam int BGW_W      = 8;
	localparam int LEN_CFG_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int LP_RESET  = 8;
	localparam int AVG_RESET = 8;
	localparam int BGW_RESET = 16;
	localparam int LEN_RESET = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LP_WEIGHT  = 2'd0,
		CFG_AVG_WEIGHT = 2'd1,
		CFG_BG_WINDOW  = 2'd2,
		CFG_TRACE_LEN  = 2'd3
	} cfg_idx_t;

	// Effective (saturated) settings seen by the back end.
	typedef struct packed {
		logic [WT_W-1:0]  lp_weight;
		logic [WT_W-1:0]  avg_weight;
		logic [BGW_W-1:0] bg_window;
	} back_cfg_t;
endpackage

// ----- src/rtcf_div.sv -----
// Restoring divider: signed dividend by unsigned 8-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module rtcf_div #(
	parameter int W = 26
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [W-1:0]              dividend,
	input  logic [rtcf_pkg::BGW_W-1:0]       divisor,
	output logic                             busy,
	output logic                             done,
	output logic signed [W-1:0]              quotient
);
	import rtcf_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     mag_q;
	logic [BGW_W-1:0] rem_q, div_q;
	logic [BGW_W:0]   trial, trial_sub;
	logic             ge;

	// One quotient bit per step
	always_comb begin
		trial     = {rem_q, mag_q[W-1]};
		trial_sub = trial - {1'b0, div_q};
		ge        = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: magnitude register fills with the quotient as it shifts
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			neg_q <= dividend[W-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[W-2:0], ge};
			rem_q <= ge ? trial_sub[BGW_W-1:0] : trial[BGW_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

// ----- src/rtcf_queue.sv -----
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
`include "radar_trace_clutter_filter_defines.svh"
module rtcf_queue #(
	parameter int W = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);
	import rtcf_pkg::*;

	logic [W-1:0] ent_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

	assign head  = ent_q[rd_q];
	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;

	`RTCF_CHK_IMPLY(a_no_push_full, push, !full, "push into full queue")
	`RTCF_CHK_IMPLY(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`RTCF_CHK_IMPLY(a_cnt_range, 1'b1, cnt_q != 2'd3, "queue count out of range")
endmodule

// ----- src/rtcf_front.sv -----
// Front end: takes sample beats, writes the trace bank, sums, posts finished traces.
`timescale 1ns / 1ps
module rtcf_front #(
	parameter int SB    = 16,
	parameter int MAX   = 64,
	parameter int IDX_W = 6,
	parameter int LEN_W = 7,
	parameter int SUM_W = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SB-1:0]              sample,
	input  logic [rtcf_pkg::LEN_CFG_W-1:0]    trace_length,
	input  logic                              q_full,
	output logic                              busy,
	output logic                              buf_we,
	output logic [IDX_W:0]                    buf_addr,
	output logic signed [SB-1:0]              buf_data,
	output logic                              push,
	output logic                              push_bank,
	output logic [LEN_W-1:0]                  push_len,
	output logic signed [SUM_W-1:0]           push_sum
);
	import rtcf_pkg::*;

	logic                    bank_q;
	logic [LEN_W-1:0]        cnt_q, cnt_nx, eff_len;
	logic signed [SUM_W-1:0] sum_q, sum_nx;
	logic                    accept, trace_done;

	// Clamp configured length to 1..MAX
	always_comb begin
		if (trace_length == '0)
			eff_len = LEN_W'(1);
		else if (trace_length > LEN_CFG_W'(MAX))
			eff_len = LEN_W'(MAX);
		else
			eff_len = LEN_W'(trace_length);
	end

	assign accept     = start && !q_full;
	assign busy       = q_full;
	assign cnt_nx     = cnt_q + 1'b1;
	assign sum_nx     = sum_q + SUM_W'(sample);
	assign trace_done = cnt_nx >= eff_len;

	assign buf_we   = accept;
	assign buf_addr = {bank_q, cnt_q[IDX_W-1:0]};
	assign buf_data = sample;

	assign push      = accept && trace_done;
	assign push_bank = bank_q;
	assign push_len  = cnt_nx;
	assign push_sum  = sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (trace_done) begin
				bank_q <= ~bank_q;
				cnt_q  <= '0;
				sum_q  <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
			end
		end
	end
endmodule

// ----- src/rtcf_back.sv -----
// Back end: mean removal, low-pass, cross-trace average, background, output beats.
`timescale 1ns / 1ps
`include "radar_trace_clutter_filter_defines.svh"
module rtcf_back #(
	parameter int SB    = 16,
	parameter int MAX   = 64,
	parameter int IDX_W = 6,
	parameter int LEN_W = 7,
	parameter int SUM_W = 22
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rtcf_pkg::back_cfg_t        cfg,
	input  logic                       q_empty,
	input  logic                       head_bank,
	input  logic [LEN_W-1:0]           head_len,
	input  logic signed [SUM_W-1:0]    head_sum,
	output logic                       pop,
	input  logic                       buf_we,
	input  logic [IDX_W:0]             buf_addr,
	input  logic signed [SB-1:0]       buf_data,
	output logic                       valid,
	output logic signed [SB+1:0]       filtered,
	output logic                       last
);
	import rtcf_pkg::*;

	localparam int X_W    = SB + 1;
	localparam int PROD_W = X_W + 6;
	localparam int NUM_W  = X_W + 9;
	localparam int OUT_W  = SB + 2;

	typedef enum logic [10:0] {
		B_IDLE = 11'b000_0000_0001,
		B_MEAN = 11'b000_0000_0010,
		B_RD   = 11'b000_0000_0100,
		B_X    = 11'b000_0000_1000,
		B_M    = 11'b000_0001_0000,
		B_D    = 11'b000_0010_0000,
		B_A    = 11'b000_0100_0000,
		B_AV   = 11'b000_1000_0000,
		B_BG   = 11'b001_0000_0000,
		B_DS   = 11'b010_0000_0000,
		B_DW   = 11'b100_0000_0000
	} bstate_t;

	bstate_t state_q, state_nx;

	// Stores
	logic signed [SB-1:0]  buf_mem [2*MAX];
	logic signed [X_W-1:0] avg_mem [MAX];
	logic signed [X_W-1:0] bg_mem  [MAX];
	logic [MAX-1:0]        avg_vld_q;

	logic signed [SB-1:0]  buf_rd_q;
	logic signed [X_W-1:0] avg_rd_q, bg_rd_q;
	logic                  vld_rd_q;

	logic [IDX_W-1:0]       idx_q;
	logic                   bg_ready_q;
	logic signed [X_W-1:0]  mean_q, x_q, d_q, a_q;
	logic signed [PROD_W-1:0] m1_q, m2_q;
	logic signed [NUM_W-1:0]  num_q;

	logic                    div_start, div_busy, div_done;
	logic signed [NUM_W-1:0] div_num, div_quot;
	logic [BGW_W-1:0]        div_den;

	logic                    valid_q, last_q;
	logic signed [OUT_W-1:0] filt_q;

	logic [WT_W-1:0]       lp_c, avg_c;
	logic [BGW_W-1:0]      wm1;
	logic signed [X_W-1:0] x_new, avg_old, bg_old, bg_new, wt_res;
	logic                  is_last;

	// Divide by sixteen, truncating toward zero
	function automatic logic signed [X_W-1:0] wt_trunc(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] s;
		s = v >>> WT_SHIFT;
		if (v[PROD_W-1] && (v[WT_SHIFT-1:0] != '0))
			s = s + PROD_W'(1);
		return X_W'(s);
	endfunction

	assign lp_c    = WT_W'(WT_FULL) - cfg.lp_weight;
	assign avg_c   = WT_W'(WT_FULL) - cfg.avg_weight;
	assign wm1     = cfg.bg_window - 1'b1;
	assign x_new   = X_W'(buf_rd_q) - mean_q;
	assign avg_old = vld_rd_q ? avg_rd_q : '0;
	assign bg_old  = bg_ready_q ? bg_rd_q : a_q;
	assign bg_new  = X_W'(div_quot);
	assign wt_res  = wt_trunc(m1_q + m2_q + PROD_W'(WT_ROUND));
	assign is_last = (LEN_W'(idx_q) + 1'b1) == head_len;

	// Shared divider: trace mean, then the background update per bin
	assign div_start = (state_q == B_IDLE && !q_empty) || (state_q == B_DS);
	assign div_num   = (state_q == B_IDLE) ? NUM_W'(head_sum) : num_q;
	assign div_den   = (state_q == B_IDLE) ? BGW_W'(head_len) : cfg.bg_window;

	rtcf_div #(.W(NUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: if (!q_empty) state_nx = B_MEAN;
			B_MEAN: if (div_done) state_nx = B_RD;
			B_RD:   state_nx = B_X;
			B_X:    state_nx = B_M;
			B_M:    state_nx = B_D;
			B_D:    state_nx = B_A;
			B_A:    state_nx = B_AV;
			B_AV:   state_nx = B_BG;
			B_BG:   state_nx = B_DS;
			B_DS:   state_nx = B_DW;
			B_DW:   if (div_done) state_nx = is_last ? B_IDLE : B_RD;
			default: state_nx = B_IDLE;
		endcase
	end

	assign pop = (state_q == B_DW) && div_done && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			idx_q      <= '0;
			bg_ready_q <= 1'b0;
			avg_vld_q  <= '0;
			valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			valid_q <= 1'b0;
			if (state_q == B_MEAN && div_done)
				idx_q <= '0;
			if (state_q == B_AV)
				avg_vld_q[idx_q] <= 1'b1;
			if (state_q == B_DW && div_done) begin
				valid_q <= 1'b1;
				if (is_last)
					bg_ready_q <= 1'b1;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Arithmetic steps
	always_ff @(posedge clk) begin
		case (state_q)
			B_MEAN: if (div_done) mean_q <= X_W'(div_quot);
			B_X: begin
				x_q <= x_new;
				if (idx_q == '0) d_q <= x_new;
			end
			B_M: begin
				m1_q <= PROD_W'($signed({1'b0, cfg.lp_weight})) * PROD_W'(d_q);
				m2_q <= PROD_W'($signed({1'b0, lp_c})) * PROD_W'(x_q);
			end
			B_D: d_q <= wt_res;
			B_A: begin
				m1_q <= PROD_W'($signed({1'b0, cfg.avg_weight})) * PROD_W'(avg_old);
				m2_q <= PROD_W'($signed({1'b0, avg_c})) * PROD_W'(d_q);
			end
			B_AV: a_q <= wt_res;
			B_BG: num_q <= NUM_W'(a_q) + NUM_W'($signed({1'b0, wm1})) * NUM_W'(bg_old);
			B_DW: if (div_done) begin
				filt_q <= OUT_W'(a_q) - OUT_W'(bg_new);
				last_q <= is_last;
			end
			default: ;
		endcase
	end

	// Memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[buf_addr] <= buf_data;
		buf_rd_q <= buf_mem[{head_bank, idx_q}];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_AV) avg_mem[idx_q] <= wt_res;
		avg_rd_q <= avg_mem[idx_q];
		vld_rd_q <= avg_vld_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DW && div_done) bg_mem[idx_q] <= bg_new;
		bg_rd_q <= bg_mem[idx_q];
	end

	assign valid    = valid_q;
	assign filtered = filt_q;
	assign last     = last_q;

	`RTCF_CHK_IMPLY(a_job_held, state_q != B_IDLE, !q_empty, "back end working without a job")
	`RTCF_CHK_IMPLY(a_div_free, div_start, !div_busy, "divider restarted while busy")
	`RTCF_CHK_NEXT(a_beat_follows, (state_q == B_DW) && div_done, valid, "result beat missing")
endmodule

// ----- src/radar_trace_clutter_filter.sv -----
// Top level: config registers, front end, job queue and back end of the clutter filter.
//
// Channel   Dir  Handshake              Payload
// sample    in   start & !busy          sample
// result    out  valid (1-cycle strobe) filtered, last
// config    in   cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Samples load at one per cycle while busy is low into a two-bank trace buffer; a full
// trace is queued. Per trace the back end runs the bit-serial divider once for the mean,
// then once per bin for the background update (NUM_W = SAMPLE_BITS+10, 26 by default).
// busy is high while both banks hold traces not yet emitted.
// Reset clears counts, valid bits of the average store and the background flag.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
module radar_trace_clutter_filter #(
	parameter int MAX_SAMPLES = rtcf_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = rtcf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	output logic                               valid,
	output logic signed [SAMPLE_BITS+1:0]      filtered,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtcf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rtcf_pkg::*;

	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + IDX_W;
	localparam int JOB_W = 1 + LEN_W + SUM_W;

	logic [WT_W-1:0]      lp_q, avg_q;
	logic [BGW_W-1:0]     bgw_q;
	logic [LEN_CFG_W-1:0] len_q;
	back_cfg_t            bcfg;

	logic                    q_full, q_empty, push, pop, push_bank;
	logic [LEN_W-1:0]        push_len;
	logic signed [SUM_W-1:0] push_sum;
	logic [JOB_W-1:0]        head;

	logic                       buf_we;
	logic [IDX_W:0]             buf_addr;
	logic signed [SAMPLE_BITS-1:0] buf_data;

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= WT_W'(LP_RESET);
			avg_q <= WT_W'(AVG_RESET);
			bgw_q <= BGW_W'(BGW_RESET);
			len_q <= LEN_CFG_W'(LEN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LP_WEIGHT:  lp_q  <= cfg_data[WT_W-1:0];
				CFG_AVG_WEIGHT: avg_q <= cfg_data[WT_W-1:0];
				CFG_BG_WINDOW:  bgw_q <= cfg_data;
				CFG_TRACE_LEN:  len_q <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated settings
	assign bcfg.lp_weight  = (lp_q > WT_W'(WT_FULL)) ? WT_W'(WT_FULL) : lp_q;
	assign bcfg.avg_weight = (avg_q > WT_W'(WT_FULL)) ? WT_W'(WT_FULL) : avg_q;
	assign bcfg.bg_window  = (bgw_q == '0) ? BGW_W'(1) : bgw_q;

	rtcf_front #(
		.SB(SAMPLE_BITS), .MAX(MAX_SAMPLES), .IDX_W(IDX_W), .LEN_W(LEN_W), .SUM_W(SUM_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sample       (sample),
		.trace_length (len_q),
		.q_full       (q_full),
		.busy         (busy),
		.buf_we       (buf_we),
		.buf_addr     (buf_addr),
		.buf_data     (buf_data),
		.push         (push),
		.push_bank    (push_bank),
		.push_len     (push_len),
		.push_sum     (push_sum)
	);

	rtcf_queue #(.W(JOB_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_bank, push_len, push_sum}),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	rtcf_back #(
		.SB(SAMPLE_BITS), .MAX(MAX_SAMPLES), .IDX_W(IDX_W), .LEN_W(LEN_W), .SUM_W(SUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (bcfg),
		.q_empty   (q_empty),
		.head_bank (head[JOB_W-1]),
		.head_len  (head[JOB_W-2:SUM_W]),
		.head_sum  ($signed(head[SUM_W-1:0])),
		.pop       (pop),
		.buf_we    (buf_we),
		.buf_addr  (buf_addr),
		.buf_data  (buf_data),
		.valid     (valid),
		.filtered  (filtered),
		.last      (last)
	);
endmodule
